>>> sv/snfp_pkg.sv
`timescale 1ns / 1ps
package snfp_pkg;

    typedef struct packed {
        logic signed [31:0] p0_x;
        logic signed [31:0] p0_y;
        logic signed [31:0] p0_z;
        logic signed [31:0] p1_x;
        logic signed [31:0] p1_y;
        logic signed [31:0] p1_z;
        logic signed [31:0] p2_x;
        logic signed [31:0] p2_y;
        logic signed [31:0] p2_z;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic               zero_length;
    } out_item_t;

    // classified job handed from front to back
    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic               norm;
    } job_t;

    localparam int QDEPTH = 2;
    localparam int QAW    = 1;

    typedef enum logic [2:0] {
        F_IDLE, F_MUL, F_SUB, F_SHIFT, F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE, B_SQUARE, B_SQRT, B_DIV, B_OUT
    } back_state_t;

endpackage

>>> sv/snfp_front.sv
`timescale 1ns / 1ps
module snfp_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  snfp_pkg::in_item_t in_data,
    input  logic               norm_en,
    output logic               push,
    output snfp_pkg::job_t     job,
    input  logic               q_full
);
    snfp_pkg::front_state_t state_reg, state_next;
    logic signed [32:0] d0_reg [3];
    logic signed [32:0] d1_reg [3];
    logic signed [63:0] prod_reg [6];
    logic signed [63:0] c_reg [3];
    logic [2:0] pidx_reg, pidx_next;
    logic norm_reg;
    logic signed [31:0] ma, mb;
    logic signed [63:0] mp;
    logic [63:0] ab [3];
    logic [31:0] hi_or;
    logic [5:0] sh;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            snfp_pkg::F_IDLE:  if (in_valid) state_next = snfp_pkg::F_MUL;
            snfp_pkg::F_MUL:   if (pidx_reg == 3'd5) state_next = snfp_pkg::F_SUB;
            snfp_pkg::F_SUB:   state_next = snfp_pkg::F_SHIFT;
            snfp_pkg::F_SHIFT: state_next = snfp_pkg::F_PUSH;
            snfp_pkg::F_PUSH:  if (!q_full) state_next = snfp_pkg::F_IDLE;
            default:           state_next = snfp_pkg::F_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == snfp_pkg::F_IDLE);
        push     = (state_reg == snfp_pkg::F_PUSH) && !q_full;
    end

    // product order: z1*y0, y1*z0, x1*z0, z1*x0, y1*x0, x1*y0
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (pidx_reg)
            3'd0: begin ma = d1_reg[2][31:0]; mb = d0_reg[1][31:0]; end
            3'd1: begin ma = d1_reg[1][31:0]; mb = d0_reg[2][31:0]; end
            3'd2: begin ma = d1_reg[0][31:0]; mb = d0_reg[2][31:0]; end
            3'd3: begin ma = d1_reg[2][31:0]; mb = d0_reg[0][31:0]; end
            3'd4: begin ma = d1_reg[1][31:0]; mb = d0_reg[0][31:0]; end
            3'd5: begin ma = d1_reg[0][31:0]; mb = d0_reg[1][31:0]; end
            default: ;
        endcase
        mp = ma * mb;
        pidx_next = (state_reg == snfp_pkg::F_MUL) ? pidx_reg + 3'd1 : 3'd0;
    end

    always_comb
    begin
        hi_or = '0;
        for (int i = 0; i < 3; i++)
        begin
            ab[i] = c_reg[i][63] ? 64'(-c_reg[i]) : 64'(c_reg[i]);
            hi_or = hi_or | ab[i][62:31];
        end
        sh = '0;
        for (int b = 0; b < 32; b++)
            if (hi_or[b]) sh = 6'(b + 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= snfp_pkg::F_IDLE;
            pidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pidx_reg  <= pidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            d0_reg[0] <= 33'(signed'(32'(in_data.p1_x - in_data.p0_x)));
            d0_reg[1] <= 33'(signed'(32'(in_data.p1_y - in_data.p0_y)));
            d0_reg[2] <= 33'(signed'(32'(in_data.p1_z - in_data.p0_z)));
            d1_reg[0] <= 33'(signed'(32'(in_data.p2_x - in_data.p1_x)));
            d1_reg[1] <= 33'(signed'(32'(in_data.p2_y - in_data.p1_y)));
            d1_reg[2] <= 33'(signed'(32'(in_data.p2_z - in_data.p1_z)));
            norm_reg  <= norm_en;
        end
        if (state_reg == snfp_pkg::F_MUL)
            prod_reg[pidx_reg] <= mp;
        if (state_reg == snfp_pkg::F_SUB)
        begin
            c_reg[0] <= prod_reg[0] - prod_reg[1];
            c_reg[1] <= prod_reg[2] - prod_reg[3];
            c_reg[2] <= prod_reg[4] - prod_reg[5];
        end
        if (state_reg == snfp_pkg::F_SHIFT)
        begin
            job.cx   <= 32'(c_reg[0] >>> sh);
            job.cy   <= 32'(c_reg[1] >>> sh);
            job.cz   <= 32'(c_reg[2] >>> sh);
            job.norm <= norm_reg;
        end
    end
endmodule

>>> sv/snfp_queue.sv
`timescale 1ns / 1ps
module snfp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  snfp_pkg::job_t wdata,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output snfp_pkg::job_t rdata
);
    snfp_pkg::job_t mem_reg [snfp_pkg::QDEPTH];
    logic [snfp_pkg::QAW-1:0] wp_reg, rp_reg;
    logic [snfp_pkg::QAW:0]   cnt_reg;

    assign full  = (cnt_reg == (snfp_pkg::QAW+1)'(snfp_pkg::QDEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (snfp_pkg::QAW+1)'(push) - (snfp_pkg::QAW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= wdata;
    end
endmodule

>>> sv/snfp_back.sv
`timescale 1ns / 1ps
module snfp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    output logic                pop,
    input  snfp_pkg::job_t      job,
    output logic                out_valid,
    input  logic                out_ready,
    output snfp_pkg::out_item_t out_data
);
    snfp_pkg::back_state_t state_reg, state_next;
    logic signed [31:0] c_reg [3];
    logic [1:0] k_reg;
    logic [63:0] sum_reg;
    logic [63:0] rem_reg, root_reg;
    logic [5:0] step_reg;
    logic [31:0] abs_c, sq_a;
    logic [63:0] sq;
    // division: unsigned |c|<<16 (48 bits) by mag (32 bits)
    logic [47:0] dq_reg;
    logic [32:0] dr_reg;
    logic [5:0]  dcnt_reg;
    logic [33:0] dtrial;
    logic [63:0] strial;
    logic [63:0] rem_sh;
    logic [31:0] res_reg [3];
    logic        flag_reg;

    function automatic logic [31:0] abs_c0(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            snfp_pkg::B_IDLE:
                if (!q_empty)
                    state_next = job.norm ? snfp_pkg::B_SQUARE : snfp_pkg::B_OUT;
            snfp_pkg::B_SQUARE: if (k_reg == 2'd2) state_next = snfp_pkg::B_SQRT;
            snfp_pkg::B_SQRT:
                if (step_reg == 6'd32)
                    state_next = (root_reg == '0) ? snfp_pkg::B_OUT : snfp_pkg::B_DIV;
            snfp_pkg::B_DIV:
                if (dcnt_reg == 6'd48 && k_reg == 2'd2) state_next = snfp_pkg::B_OUT;
            snfp_pkg::B_OUT: if (out_ready) state_next = snfp_pkg::B_IDLE;
            default: state_next = snfp_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        pop       = (state_reg == snfp_pkg::B_IDLE) && !q_empty;
        out_valid = (state_reg == snfp_pkg::B_OUT);
        out_data.normal_x    = res_reg[0];
        out_data.normal_y    = res_reg[1];
        out_data.normal_z    = res_reg[2];
        out_data.zero_length = flag_reg;
    end

    always_comb
    begin
        abs_c  = c_reg[k_reg][31] ? 32'(-c_reg[k_reg]) : 32'(c_reg[k_reg]);
        sq_a   = abs_c;
        sq     = sq_a * sq_a;
        rem_sh = {rem_reg[61:0], sum_reg[63:62]};
        strial = rem_sh - {root_reg[61:0], 2'b01};
        dtrial = {dr_reg, dq_reg[47]} - {2'b00, root_reg[31:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= snfp_pkg::B_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            snfp_pkg::B_IDLE:
                begin
                    c_reg[0] <= job.cx;
                    c_reg[1] <= job.cy;
                    c_reg[2] <= job.cz;
                    res_reg[0] <= job.cx;
                    res_reg[1] <= job.cy;
                    res_reg[2] <= job.cz;
                    flag_reg <= 1'b0;
                    k_reg    <= '0;
                    sum_reg  <= '0;
                end
            snfp_pkg::B_SQUARE:
                begin
                    sum_reg  <= sum_reg + sq;
                    k_reg    <= k_reg + 2'd1;
                    rem_reg  <= '0;
                    root_reg <= '0;
                    step_reg <= '0;
                end
            snfp_pkg::B_SQRT:
                if (step_reg != 6'd32)
                begin
                    // two bits of radicand per step, restoring
                    sum_reg  <= {sum_reg[61:0], 2'b00};
                    step_reg <= step_reg + 6'd1;
                    if (!strial[63] && rem_sh >= {root_reg[61:0], 2'b01})
                    begin
                        rem_reg  <= strial;
                        root_reg <= {root_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[62:0], 1'b0};
                    end
                end
                else
                begin
                    k_reg    <= '0;
                    dcnt_reg <= '0;
                    dr_reg   <= '0;
                    dq_reg   <= {abs_c0(c_reg[0]), 16'h0000};
                    if (root_reg == '0)
                    begin
                        flag_reg   <= 1'b1;
                        res_reg[0] <= '0;
                        res_reg[1] <= '0;
                        res_reg[2] <= '0;
                    end
                end
            snfp_pkg::B_DIV:
                if (dcnt_reg != 6'd48)
                begin
                    dcnt_reg <= dcnt_reg + 6'd1;
                    if (!dtrial[33])
                    begin
                        dr_reg <= dtrial[32:0];
                        dq_reg <= {dq_reg[46:0], 1'b1};
                    end
                    else
                    begin
                        dr_reg <= {dr_reg[31:0], dq_reg[47]};
                        dq_reg <= {dq_reg[46:0], 1'b0};
                    end
                end
                else
                begin
                    // quotient fits since |c| <= mag
                    res_reg[k_reg] <= c_reg[k_reg][31] ? 32'(-dq_reg) : dq_reg[31:0];
                    k_reg    <= k_reg + 2'd1;
                    dcnt_reg <= '0;
                    dr_reg   <= '0;
                    dq_reg   <= {abs_c0(c_reg[(k_reg == 2'd2) ? 2'd2 : k_reg + 2'd1]),
                                 16'h0000};
                end
            snfp_pkg::B_OUT: ;
            default: ;
        endcase
    end
endmodule

>>> sv/surface_normal_from_points_top.sv
`timescale 1ns / 1ps
// channel | signals                         | transfer when
// in      | in_valid, in_ready, in_data     | in_valid & in_ready at clk rise
// out     | out_valid, out_ready, out_data  | out_valid & out_ready at clk rise
// cfg     | cfg_we, cfg_data                | cfg_we at clk rise
// Front: accept, six products on one shared 32x32 multiplier, subtract, shift, push.
// Back, when normalizing: sum of squares, bit-serial square root, then a bit-serial divide per component.
// The bit-serial divider sets the item rate when normalizing; otherwise the front sets it.
// A two-entry queue lets the front take the next transfer while the back divides.
// rst_n clears control and sets norm_en_reg to 1; stalls on out hold the result.
module surface_normal_from_points_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  snfp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output snfp_pkg::out_item_t out_data
);
    logic           norm_en_reg;
    logic           push, pop, q_full, q_empty;
    snfp_pkg::job_t job_w, job_r;

    // hold the mode register; sampled per item at accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            norm_en_reg <= 1'b1;
        else if (cfg_we)
            norm_en_reg <= cfg_data;
    end

    snfp_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(in_data), .norm_en(norm_en_reg), .push(push), .job(job_w),
        .q_full(q_full)
    );

    snfp_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .wdata(job_w), .full(q_full),
        .pop(pop), .empty(q_empty), .rdata(job_r)
    );

    snfp_back u_back (
        .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .pop(pop), .job(job_r),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );
endmodule

>>> verif/tb_surface_normal_from_points_top.sv
`timescale 1ns / 1ps
module tb_surface_normal_from_points_top;

    // Scoreboard: predicts the normal for each accepted transfer and keeps the
    // predictions in order until the matching output transfer arrives.
    class normal_board;
        snfp_pkg::out_item_t pending_normals[$];
        bit        norm_on;
        int        mismatches;

        function new();
            norm_on = 1'b1;
            mismatches = 0;
        endfunction

        static function logic [63:0] mag_of(logic [63:0] v);
            logic signed [63:0] s;
            s = v;
            return (s < 0) ? -v : v;
        endfunction

        static function logic [63:0] floor_sqrt(logic [63:0] v);
            logic [63:0] root;
            logic [63:0] bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (v >= root + bitv)
                begin
                    v = v - (root + bitv);
                    root = (root >> 1) + bitv;
                end
                else
                    root = root >> 1;
                bitv = bitv >> 2;
            end
            return root;
        endfunction

        function void note_points(snfp_pkg::in_item_t p);
            logic signed [31:0] d0 [3];
            logic signed [31:0] d1 [3];
            logic signed [63:0] c [3];
            logic signed [63:0] q;
            logic [63:0] hi_or;
            logic [63:0] sum;
            logic [63:0] mag;
            logic [63:0] a;
            int shift;
            snfp_pkg::out_item_t r;
            d0[0] = p.p1_x - p.p0_x;
            d0[1] = p.p1_y - p.p0_y;
            d0[2] = p.p1_z - p.p0_z;
            d1[0] = p.p2_x - p.p1_x;
            d1[1] = p.p2_y - p.p1_y;
            d1[2] = p.p2_z - p.p1_z;
            c[0] = 64'(d1[2]) * 64'(d0[1]) - 64'(d1[1]) * 64'(d0[2]);
            c[1] = 64'(d1[0]) * 64'(d0[2]) - 64'(d1[2]) * 64'(d0[0]);
            c[2] = 64'(d1[1]) * 64'(d0[0]) - 64'(d1[0]) * 64'(d0[1]);
            hi_or = 0;
            for (int i = 0; i < 3; i++)
                hi_or = hi_or | ((mag_of(c[i]) >> 31) & 64'hFFFF_FFFF);
            shift = 0;
            while (hi_or != 0)
            begin
                shift++;
                hi_or = hi_or >> 1;
            end
            for (int i = 0; i < 3; i++)
                c[i] = 64'(signed'(32'(c[i] >>> shift)));
            r.zero_length = 1'b0;
            if (norm_on)
            begin
                sum = 0;
                for (int i = 0; i < 3; i++)
                begin
                    a = mag_of(c[i]);
                    sum = sum + a * a;
                end
                mag = floor_sqrt(sum);
                if (mag == 0)
                begin
                    r.zero_length = 1'b1;
                    for (int i = 0; i < 3; i++)
                        c[i] = 0;
                end
                else
                    for (int i = 0; i < 3; i++)
                    begin
                        q = (c[i] * 64'sd65536) / $signed(mag);
                        if (q > 64'sd2147483647)
                            q = 64'sd2147483647;
                        if (q < -64'sd2147483648)
                            q = -64'sd2147483648;
                        c[i] = q;
                    end
            end
            r.normal_x = c[0][31:0];
            r.normal_y = c[1][31:0];
            r.normal_z = c[2][31:0];
            pending_normals.push_back(r);
        endfunction

        function void check_normal(snfp_pkg::out_item_t got);
            snfp_pkg::out_item_t want;
            if (pending_normals.size() == 0)
            begin
                report_mismatch("output transfer with no prediction waiting");
                return;
            end
            want = pending_normals.pop_front();
            if (got.normal_x !== want.normal_x)
                report_mismatch($sformatf("normal_x got %h want %h",
                                          got.normal_x, want.normal_x));
            if (got.normal_y !== want.normal_y)
                report_mismatch($sformatf("normal_y got %h want %h",
                                          got.normal_y, want.normal_y));
            if (got.normal_z !== want.normal_z)
                report_mismatch($sformatf("normal_z got %h want %h",
                                          got.normal_z, want.normal_z));
            if (got.zero_length !== want.zero_length)
                report_mismatch($sformatf("zero_length got %b want %b",
                                          got.zero_length, want.zero_length));
        endfunction

        function void report_mismatch(string msg);
            mismatches++;
            if (mismatches <= 50)
                $display("mismatch at %0t: %s", $time, msg);
        endfunction
    endclass

    localparam int STALL_LIMIT = 20000;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic      cfg_data;
    logic      in_valid;
    logic      in_ready;
    snfp_pkg::in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    snfp_pkg::out_item_t out_data;

    normal_board board;
    bit          idle_free;    // suppress random idling on both sides
    bit          hold_off;     // receiver holds off for the pressure stretch
    int          quiet_cycles;

    surface_normal_from_points_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Check every output transfer at the rising edge; note inputs there too.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                board.note_points(in_data);
            if (out_valid && out_ready)
                board.check_normal(out_data);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: end the run if no transfer happens for too long.
    always @(posedge clk)
    begin
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: drop ready at random, or hold it low during the pressure stretch.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off)
            out_ready <= 1'b0;
        else if (idle_free)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 23);
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(255) << 16;    // small integer points
            3: return $urandom_range(65535) - 32768;
            default: return $urandom();
        endcase
    endfunction

    // Offer one transfer; hold valid and payload until accepted.
    task automatic send_points(snfp_pkg::in_item_t p);
        if (!idle_free)
            while ($urandom_range(99) < 23)
            begin
                in_valid = 1'b0;
                @(negedge clk);
            end
        in_valid = 1'b1;
        in_data = p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic send_random(int count, int mode);
        snfp_pkg::in_item_t p;
        logic [31:0] base;
        for (int n = 0; n < count; n++)
        begin
            p = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom(), $urandom(), $urandom()};
            if (mode == 1)
            begin
                // small triangles near a random origin, the usual geometry case
                base = $urandom();
                p.p0_x = base;
                p.p0_y = base ^ 32'h0001_0000;
                p.p0_z = base + 32'h0003_0000;
                p.p1_x = p.p0_x + $urandom_range(1 << 20) - (1 << 19);
                p.p1_y = p.p0_y + $urandom_range(1 << 20) - (1 << 19);
                p.p1_z = p.p0_z + $urandom_range(1 << 20) - (1 << 19);
                p.p2_x = p.p1_x + $urandom_range(1 << 20) - (1 << 19);
                p.p2_y = p.p1_y + $urandom_range(1 << 20) - (1 << 19);
                p.p2_z = p.p1_z + $urandom_range(1 << 20) - (1 << 19);
            end
            else if (mode == 2)
            begin
                p.p0_x = pick_coord();
                p.p1_y = pick_coord();
                p.p2_z = pick_coord();
                if ($urandom_range(3) == 0)
                begin
                    p.p2_x = p.p1_x;
                    p.p2_y = p.p1_y;
                    p.p2_z = p.p1_z;
                end
            end
            send_points(p);
        end
    endtask

    // Wait until every prediction is matched, then let the block drain.
    task automatic drain();
        while (board.pending_normals.size() != 0)
            @(negedge clk);
        repeat (400)
            @(negedge clk);
    endtask

    task automatic write_norm(bit value);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.norm_on = value;
    endtask

    task automatic run_directed();
        snfp_pkg::in_item_t p;
        p = '0;
        send_points(p);    // all points equal: zero magnitude
        p = '0;
        p.p1_x = 32'h0001_0000;
        p.p2_y = 32'h0001_0000;
        send_points(p);    // unit right triangle in the xy plane
        p = '0;
        p.p1_x = 32'h7FFF_FFFF;
        p.p2_y = 32'h8000_0000;
        send_points(p);    // edges reach the ends of the signed range
        p = '0;
        p.p0_x = 32'h8000_0000;
        p.p1_x = 32'h7FFF_FFFF;
        p.p1_y = 32'h8000_0000;
        p.p2_y = 32'h7FFF_FFFF;
        p.p2_z = 32'h8000_0000;
        send_points(p);    // largest products: shift count reaches its top
        p = {9{32'hFFFF_FFFF}};
        send_points(p);
        p = {32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        send_points(p);
        p = '0;
        p.p1_x = 32'h0002_0000;
        p.p2_x = 32'h0004_0000;
        send_points(p);    // collinear points
        p = '0;
        p.p1_z = 32'h0000_0001;
        p.p2_x = 32'hFFFF_FFFF;
        send_points(p);    // tiny cross product, no shift
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        idle_free = 1'b0;
        hold_off = 1'b0;
        quiet_cycles = 0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset value: normalizing on
        run_directed();
        drain();
        write_norm(1'b0);
        run_directed();
        send_random(100, 2);
        drain();
        write_norm(1'b1);

        // pressure: receiver stalls while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                repeat (1500)
                    @(negedge clk);
                hold_off = 1'b0;
            end
            send_random(10, 1);
        join

        send_random(150, 1);
        idle_free = 1'b1;
        send_random(60, 0);
        idle_free = 1'b0;
        send_random(60, 2);
        drain();
        write_norm(1'b0);
        send_random(100, 1);
        send_random(40, 0);
        drain();
        write_norm(1'b1);
        send_random(40, 0);
        drain();

        if (board.mismatches == 0 && board.pending_normals.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

>>> files.f
sv/snfp_pkg.sv
sv/snfp_front.sv
sv/snfp_queue.sv
sv/snfp_back.sv
sv/surface_normal_from_points_top.sv
verif/tb_surface_normal_from_points_top.sv
